@@ rtl/core/c2c_pkg.sv @@
// shared types and constants for the coo to csc converter
`default_nettype none

package c2c_pkg;

  localparam int MAX_DIM_DEF     = 1024;
  localparam int MAX_ENTRIES_DEF = 4096;

  localparam int DIM_W      = 11;
  localparam int DIM_RESET  = 1024;
  localparam int OP_W       = 2;
  localparam int IDX_IN_W   = 11;
  localparam int VAL_W      = 64;
  localparam int RIDX_W     = 13;
  localparam int STATUS_W   = 2;
  localparam int PTR_OUT_W  = 13;
  localparam int ROW_OUT_W  = 10;
  localparam int CNT_OUT_W  = 13;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 2'd0,
    OP_FINISH   = 2'd1,
    OP_RD_PTR   = 2'd2,
    OP_RD_ENTRY = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_BUILT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDATA,
    S_CLR,
    S_CNT_RD,
    S_CNT_CP,
    S_CNT_WR,
    S_SCAN_RD,
    S_SCAN_WR,
    S_SCT_RD,
    S_SCT_CP,
    S_SCT_WR
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/coo_to_csc_converter.sv @@
// top level of the coo to csc converter: triplet store, build sequencer and reads
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------------------
//  in       | input     | in_valid_i / in_ready_o | op, row_in, col_in, value_in, read_index
//  out      | output    | out_valid_o/out_ready_i | status, pointer_out, row_out, value_out,
//           |           |                         | entry_count, error_seen
//  cfg      | input     | cfg_we_i                | dimension
//
//  a pointer or entry read does one ram read, then loads the result register
//  a finish runs a clear of the pointer ram, two ram round trips per triplet for counting
//  and scattering, and one read and one write per pointer for the prefix sum, all through
//  the single pointer ram port
//  one input beat is held while a result beat waits on out_ready_i
//  reset clears control state only; ram contents are undefined and need no clearing pass
`default_nettype none

module coo_to_csc_converter #(
  parameter int MAX_DIM     = c2c_pkg::MAX_DIM_DEF,
  parameter int MAX_ENTRIES = c2c_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [c2c_pkg::DIM_W-1:0]       dimension_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic [c2c_pkg::OP_W-1:0]        op_i,
  input  wire logic [c2c_pkg::IDX_IN_W-1:0]    row_in_i,
  input  wire logic [c2c_pkg::IDX_IN_W-1:0]    col_in_i,
  input  wire logic [c2c_pkg::VAL_W-1:0]       value_in_i,
  input  wire logic [c2c_pkg::RIDX_W-1:0]      read_index_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic [c2c_pkg::STATUS_W-1:0]    status_o,
  output      logic [c2c_pkg::PTR_OUT_W-1:0]   pointer_out_o,
  output      logic [c2c_pkg::ROW_OUT_W-1:0]   row_out_o,
  output      logic [c2c_pkg::VAL_W-1:0]       value_out_o,
  output      logic [c2c_pkg::CNT_OUT_W-1:0]   entry_count_o,
  output      logic                            error_seen_o
);

  localparam int DimW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int EntW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW     = $clog2(MAX_ENTRIES + 1);
  localparam int EdW      = $clog2(MAX_DIM + 1);
  localparam int CpDepth  = MAX_DIM + 2;
  localparam int CpAW     = $clog2(CpDepth);
  localparam int ValW     = c2c_pkg::VAL_W;
  localparam int TripW    = 2 * DimW + ValW;
  localparam int SrtW     = DimW + ValW;
  localparam int EffReset = (c2c_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : c2c_pkg::DIM_RESET;
  localparam int PtrOutW  = c2c_pkg::PTR_OUT_W;
  localparam int RowOutW  = c2c_pkg::ROW_OUT_W;
  localparam int CntOutW  = c2c_pkg::CNT_OUT_W;
  localparam int IdxInW   = c2c_pkg::IDX_IN_W;
  localparam int RidxW    = c2c_pkg::RIDX_W;

  c2c_pkg::state_e  state_q, state_d;

  // held input beat
  logic                  item_valid_q;
  c2c_pkg::op_e          item_op_q;
  logic [IdxInW-1:0]     item_row_q, item_col_q;
  logic [ValW-1:0]       item_val_q;
  logic [RidxW-1:0]      item_idx_q;
  logic                  item_take;

  // matrix state
  logic [CntW-1:0]       loaded_q, loaded_d;
  logic                  zb_q, zb_d;
  logic                  decided_q, decided_d;
  logic                  built_q, built_d;
  logic                  err_q, err_d;
  logic [EdW-1:0]        eff_dim_q, eff_dim_d;

  // build counters
  logic [CpAW-1:0]       j_q, j_d;
  logic [EntW-1:0]       k_q, k_d;
  logic [CntW-1:0]       sum_q, sum_d;

  c2c_pkg::status_e      rd_status_q, rd_status_d;
  c2c_pkg::op_e          rd_op_q, rd_op_d;

  // result register
  logic                  out_valid_q;
  c2c_pkg::status_e      out_status_q;
  logic [PtrOutW-1:0]    out_ptr_q;
  logic [RowOutW-1:0]    out_row_q;
  logic [ValW-1:0]       out_val_q;
  logic [CntOutW-1:0]    out_count_q;
  logic                  out_err_q;
  logic                  out_free, out_load, build_done;
  c2c_pkg::status_e      res_status;
  logic [PtrOutW-1:0]    res_ptr;
  logic [RowOutW-1:0]    res_row;
  logic [ValW-1:0]       res_val;

  // rams
  logic                  trip_req, trip_we;
  logic [EntW-1:0]       trip_addr;
  logic [TripW-1:0]      trip_wdata, trip_rdata;
  logic                  cp_req, cp_we;
  logic [CpAW-1:0]       cp_addr;
  logic [CntW-1:0]       cp_wdata, cp_rdata;
  logic                  srt_req, srt_we;
  logic [EntW-1:0]       srt_addr;
  logic [SrtW-1:0]       srt_wdata, srt_rdata;

  logic [DimW-1:0]       trip_row, trip_col;
  logic [ValW-1:0]       trip_val;

  // load datapath
  logic                  zb_eff, row_neg, col_neg, load_range_err, store_full;
  logic [IdxInW-1:0]     row_adj, col_adj;
  c2c_pkg::status_e      ptr_status, ent_status;
  logic                  j_last, k_last, cnt_none;
  logic [EdW-1:0]        eff_cfg;

  assign trip_row = trip_rdata[TripW-1 -: DimW];
  assign trip_col = trip_rdata[ValW +: DimW];
  assign trip_val = trip_rdata[ValW-1:0];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !item_valid_q || item_take;

  assign zb_eff  = decided_q ? zb_q : (item_row_q == '0 || item_col_q == '0);
  assign row_adj = zb_eff ? item_row_q : item_row_q - 1'b1;
  assign col_adj = zb_eff ? item_col_q : item_col_q - 1'b1;
  assign row_neg = !zb_eff && (item_row_q == '0);
  assign col_neg = !zb_eff && (item_col_q == '0);
  assign load_range_err = row_neg || col_neg
                       || (32'(row_adj) >= 32'(eff_dim_q))
                       || (32'(col_adj) >= 32'(eff_dim_q));
  assign store_full = 32'(loaded_q) >= MAX_ENTRIES;

  assign ptr_status = !built_q ? c2c_pkg::ST_NOT_BUILT
                    : (32'(item_idx_q) > 32'(eff_dim_q)) ? c2c_pkg::ST_RANGE
                    : c2c_pkg::ST_OK;
  assign ent_status = !built_q ? c2c_pkg::ST_NOT_BUILT
                    : (32'(item_idx_q) >= 32'(loaded_q)) ? c2c_pkg::ST_RANGE
                    : c2c_pkg::ST_OK;

  assign j_last   = 32'(j_q) == 32'(eff_dim_q) + 32'd1;
  assign k_last   = 32'(k_q) + 32'd1 == 32'(loaded_q);
  assign cnt_none = loaded_q == '0;
  assign eff_cfg  = (32'(dimension_i) > MAX_DIM) ? EdW'(MAX_DIM) : EdW'(dimension_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      c2c_pkg::S_IDLE: begin
        if (item_valid_q && out_free) begin
          case (item_op_q)
            c2c_pkg::OP_LOAD:   state_d = c2c_pkg::S_IDLE;
            c2c_pkg::OP_FINISH: state_d = c2c_pkg::S_CLR;
            default:            state_d = c2c_pkg::S_RDATA;
          endcase
        end
      end
      c2c_pkg::S_RDATA: state_d = c2c_pkg::S_IDLE;
      c2c_pkg::S_CLR: begin
        if (j_last) begin
          state_d = cnt_none ? c2c_pkg::S_SCAN_RD : c2c_pkg::S_CNT_RD;
        end
      end
      c2c_pkg::S_CNT_RD: state_d = c2c_pkg::S_CNT_CP;
      c2c_pkg::S_CNT_CP: state_d = c2c_pkg::S_CNT_WR;
      c2c_pkg::S_CNT_WR: state_d = k_last ? c2c_pkg::S_SCAN_RD : c2c_pkg::S_CNT_RD;
      c2c_pkg::S_SCAN_RD: state_d = c2c_pkg::S_SCAN_WR;
      c2c_pkg::S_SCAN_WR: begin
        if (j_last) begin
          state_d = cnt_none ? c2c_pkg::S_IDLE : c2c_pkg::S_SCT_RD;
        end else begin
          state_d = c2c_pkg::S_SCAN_RD;
        end
      end
      c2c_pkg::S_SCT_RD: state_d = c2c_pkg::S_SCT_CP;
      c2c_pkg::S_SCT_CP: state_d = c2c_pkg::S_SCT_WR;
      c2c_pkg::S_SCT_WR: state_d = k_last ? c2c_pkg::S_IDLE : c2c_pkg::S_SCT_RD;
      default: state_d = c2c_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    trip_req    = 1'b0;
    trip_we     = 1'b0;
    trip_addr   = k_q;
    trip_wdata  = {DimW'(row_adj), DimW'(col_adj), item_val_q};
    cp_req      = 1'b0;
    cp_we       = 1'b0;
    cp_addr     = j_q;
    cp_wdata    = '0;
    srt_req     = 1'b0;
    srt_we      = 1'b0;
    srt_addr    = EntW'(item_idx_q);
    srt_wdata   = {trip_row, trip_val};
    item_take   = 1'b0;
    out_load    = 1'b0;
    build_done  = 1'b0;
    res_status  = c2c_pkg::ST_OK;
    res_ptr     = '0;
    res_row     = '0;
    res_val     = '0;
    loaded_d    = loaded_q;
    zb_d        = zb_q;
    decided_d   = decided_q;
    built_d     = built_q;
    err_d       = err_q;
    eff_dim_d   = eff_dim_q;
    j_d         = j_q;
    k_d         = k_q;
    sum_d       = sum_q;
    rd_status_d = rd_status_q;
    rd_op_d     = rd_op_q;
    case (state_q)
      c2c_pkg::S_IDLE: begin
        if (item_valid_q && out_free) begin
          item_take = 1'b1;
          case (item_op_q)
            c2c_pkg::OP_LOAD: begin
              decided_d = 1'b1;
              zb_d      = zb_eff;
              built_d   = 1'b0;
              out_load  = 1'b1;
              if (load_range_err) begin
                err_d      = 1'b1;
                res_status = c2c_pkg::ST_RANGE;
              end else if (store_full) begin
                err_d      = 1'b1;
                res_status = c2c_pkg::ST_FULL;
              end else begin
                trip_req  = 1'b1;
                trip_we   = 1'b1;
                trip_addr = EntW'(loaded_q);
                loaded_d  = loaded_q + 1'b1;
              end
            end
            c2c_pkg::OP_FINISH: begin
              j_d   = '0;
              k_d   = '0;
              sum_d = '0;
            end
            c2c_pkg::OP_RD_PTR: begin
              cp_req      = 1'b1;
              cp_addr     = CpAW'(item_idx_q);
              rd_op_d     = c2c_pkg::OP_RD_PTR;
              rd_status_d = ptr_status;
            end
            default: begin
              srt_req     = 1'b1;
              rd_op_d     = c2c_pkg::OP_RD_ENTRY;
              rd_status_d = ent_status;
            end
          endcase
        end
      end
      c2c_pkg::S_RDATA: begin
        out_load   = 1'b1;
        res_status = rd_status_q;
        if (rd_status_q == c2c_pkg::ST_OK) begin
          if (rd_op_q == c2c_pkg::OP_RD_PTR) begin
            res_ptr = PtrOutW'(cp_rdata);
          end else begin
            res_row = RowOutW'(srt_rdata[SrtW-1 -: DimW]);
            res_val = srt_rdata[ValW-1:0];
          end
        end
      end
      c2c_pkg::S_CLR: begin
        cp_req = 1'b1;
        cp_we  = 1'b1;
        j_d    = j_last ? '0 : j_q + 1'b1;
      end
      c2c_pkg::S_CNT_RD: begin
        trip_req = 1'b1;
      end
      c2c_pkg::S_CNT_CP: begin
        cp_req  = 1'b1;
        cp_addr = CpAW'(32'(trip_col) + 32'd2);
      end
      c2c_pkg::S_CNT_WR: begin
        cp_req   = 1'b1;
        cp_we    = 1'b1;
        cp_addr  = CpAW'(32'(trip_col) + 32'd2);
        cp_wdata = cp_rdata + 1'b1;
        k_d      = k_last ? '0 : k_q + 1'b1;
      end
      c2c_pkg::S_SCAN_RD: begin
        cp_req = 1'b1;
      end
      c2c_pkg::S_SCAN_WR: begin
        cp_req   = 1'b1;
        cp_we    = 1'b1;
        cp_wdata = sum_q + cp_rdata;
        sum_d    = sum_q + cp_rdata;
        j_d      = j_q + 1'b1;
        build_done = j_last && cnt_none;
      end
      c2c_pkg::S_SCT_RD: begin
        trip_req = 1'b1;
      end
      c2c_pkg::S_SCT_CP: begin
        cp_req  = 1'b1;
        cp_addr = CpAW'(32'(trip_col) + 32'd1);
      end
      c2c_pkg::S_SCT_WR: begin
        srt_req    = 1'b1;
        srt_we     = 1'b1;
        srt_addr   = EntW'(cp_rdata);
        cp_req     = 1'b1;
        cp_we      = 1'b1;
        cp_addr    = CpAW'(32'(trip_col) + 32'd1);
        cp_wdata   = cp_rdata + 1'b1;
        k_d        = k_q + 1'b1;
        build_done = k_last;
      end
      default: begin
        item_take = 1'b0;
      end
    endcase
    if (build_done) begin
      built_d  = 1'b1;
      out_load = 1'b1;
    end
    if (cfg_we_i) begin
      eff_dim_d = eff_cfg;
      loaded_d  = '0;
      built_d   = 1'b0;
      decided_d = 1'b0;
      zb_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= c2c_pkg::S_IDLE;
      item_valid_q <= 1'b0;
      loaded_q     <= '0;
      zb_q         <= 1'b0;
      decided_q    <= 1'b0;
      built_q      <= 1'b0;
      err_q        <= 1'b0;
      eff_dim_q    <= EdW'(EffReset);
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      loaded_q  <= loaded_d;
      zb_q      <= zb_d;
      decided_q <= decided_d;
      built_q   <= built_d;
      err_q     <= err_d;
      eff_dim_q <= eff_dim_d;
      if (in_valid_i && in_ready_o) begin
        item_valid_q <= 1'b1;
      end else if (item_take) begin
        item_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_op_q  <= c2c_pkg::op_e'(op_i);
      item_row_q <= row_in_i;
      item_col_q <= col_in_i;
      item_val_q <= value_in_i;
      item_idx_q <= read_index_i;
    end
    j_q         <= j_d;
    k_q         <= k_d;
    sum_q       <= sum_d;
    rd_status_q <= rd_status_d;
    rd_op_q     <= rd_op_d;
    if (out_load) begin
      out_status_q <= res_status;
      out_ptr_q    <= res_ptr;
      out_row_q    <= res_row;
      out_val_q    <= res_val;
      out_count_q  <= CntOutW'(loaded_d);
      out_err_q    <= err_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign pointer_out_o = out_ptr_q;
  assign row_out_o     = out_row_q;
  assign value_out_o   = out_val_q;
  assign entry_count_o = out_count_q;
  assign error_seen_o  = out_err_q;

  c2c_ram #(
    .Width (TripW),
    .Depth (MAX_ENTRIES)
  ) u_trip_ram (
    .clk_i   (clk_i),
    .req_i   (trip_req),
    .we_i    (trip_we),
    .addr_i  (trip_addr),
    .wdata_i (trip_wdata),
    .rdata_o (trip_rdata)
  );

  c2c_ram #(
    .Width (CntW),
    .Depth (CpDepth)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .req_i   (cp_req),
    .we_i    (cp_we),
    .addr_i  (cp_addr),
    .wdata_i (cp_wdata),
    .rdata_o (cp_rdata)
  );

  c2c_ram #(
    .Width (SrtW),
    .Depth (MAX_ENTRIES)
  ) u_sorted_ram (
    .clk_i   (clk_i),
    .req_i   (srt_req),
    .we_i    (srt_we),
    .addr_i  (srt_addr),
    .wdata_i (srt_wdata),
    .rdata_o (srt_rdata)
  );

  // a result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // scatter lands inside the stored range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == c2c_pkg::S_SCT_WR) |-> (32'(cp_rdata) < 32'(loaded_q)))
    else $error("scatter position beyond stored triplets");

  // error flag is sticky
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("error flag dropped");

  // triplet count holds during a build
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != c2c_pkg::S_IDLE && !cfg_we_i) |=> $stable(loaded_q))
    else $error("triplet count changed during build");

endmodule

`default_nettype wire

@@ rtl/core/c2c_ram.sv @@
// single port ram with registered read
`default_nettype none

module c2c_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       req_i,
  input  wire logic                                       we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  output      logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_coo_to_csc_converter.sv @@
// testbench for the coo to csc converter: predicted results checked beat by beat, with and without random idling
module tb_coo_to_csc_converter;

  localparam int WATCHDOG_LIMIT = 150000;
  localparam int PHASE_BEATS    = 330;

  localparam int DimW     = c2c_pkg::DIM_W;
  localparam int DimReset = c2c_pkg::DIM_RESET;
  localparam int OpW      = c2c_pkg::OP_W;
  localparam int IdxW     = c2c_pkg::IDX_IN_W;
  localparam int ValW     = c2c_pkg::VAL_W;
  localparam int RidxW    = c2c_pkg::RIDX_W;
  localparam int StW      = c2c_pkg::STATUS_W;
  localparam int PtrW     = c2c_pkg::PTR_OUT_W;
  localparam int RowW     = c2c_pkg::ROW_OUT_W;
  localparam int CntW     = c2c_pkg::CNT_OUT_W;
  localparam int MaxDim   = c2c_pkg::MAX_DIM_DEF;
  localparam int MaxEnt   = c2c_pkg::MAX_ENTRIES_DEF;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic [DimW-1:0]   dimension_i  = DimW'(DimReset);
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [OpW-1:0]    op_i         = c2c_pkg::OP_LOAD;
  logic [IdxW-1:0]   row_in_i     = '0;
  logic [IdxW-1:0]   col_in_i     = '0;
  logic [ValW-1:0]   value_in_i   = '0;
  logic [RidxW-1:0]  read_index_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [StW-1:0]    status_o;
  logic [PtrW-1:0]   pointer_out_o;
  logic [RowW-1:0]   row_out_o;
  logic [ValW-1:0]   value_out_o;
  logic [CntW-1:0]   entry_count_o;
  logic              error_seen_o;

  int send_idle_pct = 10;
  int stall_pct     = 49;
  int beats_sent    = 0;
  int quiet_cycles  = 0;

  typedef struct packed {
    c2c_pkg::status_e status;
    logic [PtrW-1:0]  ptr;
    logic [RowW-1:0]  row;
    logic [ValW-1:0]  val;
    logic [CntW-1:0]  cnt;
    logic             err;
  } csc_result_t;

  class csc_scoreboard;
    int               trip_row [MaxEnt];
    int               trip_col [MaxEnt];
    logic [ValW-1:0]  trip_val [MaxEnt];
    int               col_ptr  [MaxDim+1];
    int               next_slot[MaxDim];
    logic [RowW-1:0]  csc_row  [MaxEnt];
    logic [ValW-1:0]  csc_val  [MaxEnt];
    int               dim;
    int               count;
    bit               zero_indexed;
    bit               base_set;
    bit               built;
    bit               err_flag;
    int               failures;
    csc_result_t      pending_results[$];

    function new();
      dim          = DimReset;
      count        = 0;
      zero_indexed = 1'b0;
      base_set     = 1'b0;
      built        = 1'b0;
      err_flag     = 1'b0;
      failures     = 0;
    endfunction

    function int eff_dim();
      return (dim > MaxDim) ? MaxDim : dim;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_dimension(logic [DimW-1:0] d);
      dim          = int'(d);
      count        = 0;
      built        = 1'b0;
      base_set     = 1'b0;
      zero_indexed = 1'b0;
    endfunction

    function c2c_pkg::status_e load_triplet(logic [IdxW-1:0] r_raw, logic [IdxW-1:0] c_raw,
                                            logic [ValW-1:0] v);
      int r;
      int c;
      int d;
      d = eff_dim();
      r = int'(r_raw);
      c = int'(c_raw);
      if (!base_set) begin
        base_set     = 1'b1;
        zero_indexed = (r_raw == '0) || (c_raw == '0);
      end
      if (!zero_indexed) begin
        r = r - 1;
        c = c - 1;
      end
      built = 1'b0;
      if (r < 0 || r >= d || c < 0 || c >= d) begin
        err_flag = 1'b1;
        return c2c_pkg::ST_RANGE;
      end
      if (count >= MaxEnt) begin
        err_flag = 1'b1;
        return c2c_pkg::ST_FULL;
      end
      trip_row[count] = r;
      trip_col[count] = c;
      trip_val[count] = v;
      count++;
      return c2c_pkg::ST_OK;
    endfunction

    function void build_columns();
      int d;
      int j;
      int k;
      int p;
      int sum;
      d   = eff_dim();
      sum = 0;
      for (j = 0; j <= d; j++) col_ptr[j] = 0;
      for (k = 0; k < count; k++)
        if (trip_col[k] < d) col_ptr[trip_col[k] + 1]++;
      for (j = 0; j < d; j++) begin
        sum            += col_ptr[j + 1];
        col_ptr[j + 1]  = sum;
        next_slot[j]    = col_ptr[j];
      end
      // stable scatter, load order kept within a column
      for (k = 0; k < count; k++) begin
        if (trip_col[k] < d) begin
          p = next_slot[trip_col[k]];
          if (p < MaxEnt) begin
            csc_row[p] = RowW'(trip_row[k]);
            csc_val[p] = trip_val[k];
          end
          next_slot[trip_col[k]] = p + 1;
        end
      end
      built = 1'b1;
    endfunction

    function void note_beat(c2c_pkg::op_e op, logic [IdxW-1:0] r_raw,
                            logic [IdxW-1:0] c_raw, logic [ValW-1:0] v,
                            logic [RidxW-1:0] idx);
      csc_result_t res;
      res        = '0;
      res.status = c2c_pkg::ST_OK;
      case (op)
        c2c_pkg::OP_LOAD: begin
          res.status = load_triplet(r_raw, c_raw, v);
        end
        c2c_pkg::OP_FINISH: begin
          build_columns();
        end
        c2c_pkg::OP_RD_PTR: begin
          if (!built) res.status = c2c_pkg::ST_NOT_BUILT;
          else if (int'(idx) > eff_dim()) res.status = c2c_pkg::ST_RANGE;
          else res.ptr = PtrW'(col_ptr[idx]);
        end
        default: begin
          if (!built) res.status = c2c_pkg::ST_NOT_BUILT;
          else if (int'(idx) >= count || int'(idx) >= MaxEnt) res.status = c2c_pkg::ST_RANGE;
          else begin
            res.row = csc_row[idx];
            res.val = csc_val[idx];
          end
        end
      endcase
      res.cnt = CntW'(count);
      res.err = err_flag;
      pending_results.push_back(res);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_beat(logic [StW-1:0] st, logic [PtrW-1:0] ptr,
                             logic [RowW-1:0] row, logic [ValW-1:0] val,
                             logic [CntW-1:0] cnt, logic err);
      csc_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0h", $time, st);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare("status", 64'(want.status), 64'(st));
      compare("pointer_out", 64'(want.ptr), 64'(ptr));
      compare("row_out", 64'(want.row), 64'(row));
      compare("value_out", want.val, val);
      compare("entry_count", 64'(want.cnt), 64'(cnt));
      compare("error_seen", 64'(want.err), 64'(err));
    endfunction
  endclass

  csc_scoreboard sb;

  coo_to_csc_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .dimension_i   (dimension_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .row_in_i      (row_in_i),
    .col_in_i      (col_in_i),
    .value_in_i    (value_in_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .pointer_out_o (pointer_out_o),
    .row_out_o     (row_out_o),
    .value_out_o   (value_out_o),
    .entry_count_o (entry_count_o),
    .error_seen_o  (error_seen_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_beat(c2c_pkg::op_e'(op_i), row_in_i, col_in_i, value_in_i, read_index_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_beat(status_o, pointer_out_o, row_out_o, value_out_o, entry_count_o,
                    error_seen_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("coo_to_csc_converter test failed");
      $finish;
    end
  end

  function automatic logic [ValW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IdxW-1:0] rand_coord();
    return IdxW'($urandom);
  endfunction

  function automatic logic [RidxW-1:0] rand_ridx();
    return RidxW'($urandom);
  endfunction

  task automatic send_beat(input c2c_pkg::op_e op, input logic [IdxW-1:0] r,
                           input logic [IdxW-1:0] c, input logic [ValW-1:0] v,
                           input logic [RidxW-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    row_in_i     <= r;
    col_in_i     <= c;
    value_in_i   <= v;
    read_index_i <= idx;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    beats_sent++;
  endtask

  // drain all results first, the register is only written while idle
  task automatic write_dimension(input logic [DimW-1:0] d);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    cfg_we_i    <= 1'b1;
    dimension_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_dimension(d);
  endtask

  task automatic matrix_round();
    int               kind;
    int               d;
    int               de;
    int               n;
    int               k;
    int               r;
    int               c;
    int               reads;
    bit               one_based;
    c2c_pkg::op_e     rd_op;
    logic [IdxW-1:0]  ri;
    logic [IdxW-1:0]  ci;
    logic [RidxW-1:0] idx;
    kind = $urandom_range(99);
    if (kind < 4) d = 0;
    else if (kind < 8) d = MaxDim;
    else if (kind < 11) d = $urandom_range(2047, MaxDim + 1);
    else d = $urandom_range(16, 1);
    de = (d > MaxDim) ? MaxDim : d;
    write_dimension(DimW'(d));
    one_based = 1'($urandom_range(1));
    n         = $urandom_range(24);
    if ($urandom_range(9) == 0)
      send_beat($urandom_range(1) ? c2c_pkg::OP_RD_PTR : c2c_pkg::OP_RD_ENTRY, rand_coord(),
                rand_coord(), rand_word(), rand_ridx());
    for (k = 0; k < n; k++) begin
      if (de == 0 || $urandom_range(9) == 0) begin
        ri = rand_coord();
        ci = rand_coord();
      end else begin
        r = $urandom_range(de - 1);
        c = $urandom_range(de - 1);
        if (k == 0 && !one_based) r = 0;
        ri = IdxW'(r + int'(one_based));
        ci = IdxW'(c + int'(one_based));
      end
      send_beat(c2c_pkg::OP_LOAD, ri, ci, rand_word(), rand_ridx());
    end
    send_beat(c2c_pkg::OP_FINISH, rand_coord(), rand_coord(), rand_word(), rand_ridx());
    if ($urandom_range(9) == 0)
      send_beat(c2c_pkg::OP_FINISH, rand_coord(), rand_coord(), rand_word(), rand_ridx());
    if ($urandom_range(99) < 15) begin
      // load after build drops the built state
      send_beat(c2c_pkg::OP_LOAD, IdxW'($urandom_range(de)), IdxW'($urandom_range(de)),
                rand_word(), rand_ridx());
      n++;
      send_beat(c2c_pkg::OP_RD_ENTRY, rand_coord(), rand_coord(), rand_word(),
                RidxW'($urandom_range(n)));
      send_beat(c2c_pkg::OP_FINISH, rand_coord(), rand_coord(), rand_word(), rand_ridx());
    end
    reads = $urandom_range(12, 2);
    for (k = 0; k < reads; k++) begin
      rd_op = $urandom_range(1) ? c2c_pkg::OP_RD_PTR : c2c_pkg::OP_RD_ENTRY;
      if ($urandom_range(9) == 0) idx = rand_ridx();
      else if (rd_op == c2c_pkg::OP_RD_PTR) idx = RidxW'($urandom_range(de));
      else idx = RidxW'($urandom_range(n));
      send_beat(rd_op, rand_coord(), rand_coord(), rand_word(), idx);
    end
  endtask

  task automatic run_rounds(input int target);
    int start;
    start = beats_sent;
    while (beats_sent - start < target) matrix_round();
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset dimension, reads before any build
    send_beat(c2c_pkg::OP_RD_PTR, '0, '0, '0, '0);
    send_beat(c2c_pkg::OP_RD_ENTRY, '0, '0, '0, '0);
    send_beat(c2c_pkg::OP_LOAD, 11'd0, 11'd0, '1, '0);
    send_beat(c2c_pkg::OP_LOAD, 11'd1023, 11'd1023, '0, '1);
    send_beat(c2c_pkg::OP_LOAD, 11'd1024, 11'd7, 64'h0123_4567_89ab_cdef, '0);
    send_beat(c2c_pkg::OP_FINISH, '0, '0, '0, '0);
    send_beat(c2c_pkg::OP_RD_PTR, '0, '0, '0, 13'd0);
    send_beat(c2c_pkg::OP_RD_PTR, '0, '0, '0, 13'd1024);
    send_beat(c2c_pkg::OP_RD_PTR, '0, '0, '0, 13'd1025);
    send_beat(c2c_pkg::OP_RD_ENTRY, '0, '0, '0, 13'd1);
    send_beat(c2c_pkg::OP_RD_ENTRY, '0, '0, '0, 13'd2);
    send_beat(c2c_pkg::OP_RD_ENTRY, '0, '0, '0, 13'd8191);
    send_beat(c2c_pkg::OP_FINISH, '0, '0, '0, '0);
    send_beat(c2c_pkg::OP_LOAD, 11'd2047, 11'd2047, '1, '0);
    send_beat(c2c_pkg::OP_RD_ENTRY, '0, '0, '0, 13'd0);

    // one-based indices on the smallest matrix
    write_dimension(11'd1);
    send_beat(c2c_pkg::OP_LOAD, 11'd1, 11'd1, 64'hfedc_ba98_7654_3210, '0);
    send_beat(c2c_pkg::OP_LOAD, 11'd2, 11'd1, '1, '0);
    send_beat(c2c_pkg::OP_FINISH, '0, '0, '0, '0);
    send_beat(c2c_pkg::OP_RD_PTR, '0, '0, '0, 13'd1);
    send_beat(c2c_pkg::OP_RD_ENTRY, '0, '0, '0, 13'd0);

    // empty matrix rejects every triplet
    write_dimension(11'd0);
    send_beat(c2c_pkg::OP_LOAD, 11'd0, 11'd0, '1, '0);
    send_beat(c2c_pkg::OP_FINISH, '0, '0, '0, '0);
    send_beat(c2c_pkg::OP_RD_PTR, '0, '0, '0, 13'd0);

    // dimension above the maximum is clamped
    write_dimension(11'd2047);
    send_beat(c2c_pkg::OP_LOAD, 11'd0, 11'd1024, '1, '0);
    send_beat(c2c_pkg::OP_LOAD, 11'd1023, 11'd0, 64'h8000_0000_0000_0001, '0);
    send_beat(c2c_pkg::OP_FINISH, '0, '0, '0, '0);
    send_beat(c2c_pkg::OP_RD_PTR, '0, '0, '0, 13'd1024);

    run_rounds(PHASE_BEATS);

    send_idle_pct = 49;
    stall_pct     = 10;
    run_rounds(PHASE_BEATS);

    send_idle_pct = 0;
    stall_pct     = 0;
    run_rounds(PHASE_BEATS);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (8) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("coo_to_csc_converter test passed");
    end else begin
      $display("coo_to_csc_converter test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/c2c_pkg.sv
rtl/core/c2c_ram.sv
rtl/core/coo_to_csc_converter.sv
verif/tb_coo_to_csc_converter.sv
